// File: rtl/mte_pkg.sv
package mte_pkg;

  localparam int unsigned NumStages = 13;
  localparam logic [25:0] UsecPerMin = 26'd60000000;
  localparam logic [23:0] QuotMax = 24'hFFFFFF;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_TEMPO    = 2'd2,
    KIND_DELTA    = 2'd3
  } kind_t;

  // one event in flight through the divider
  typedef struct packed {
    kind_t       kind;
    logic [27:0] delta;
    logic [3:0]  chan;
    logic [6:0]  note;
    logic        bzero;
    logic [15:0] dvs;
    logic [15:0] rem;
    logic [25:0] quot;
  } div_st_t;

  // two restoring division steps
  function automatic div_st_t div_step(div_st_t s, logic [1:0] dbits);
    div_st_t     o;
    logic [16:0] r;
    logic        qb;
    o = s;
    r = {1'b0, s.rem};
    for (int j = 1; j >= 0; j--) begin
      r = {r[15:0], dbits[j]};
      qb = 1'b0;
      if (r >= {1'b0, o.dvs}) begin
        r = r - {1'b0, o.dvs};
        qb = 1'b1;
      end
      o.quot = {o.quot[24:0], qb};
    end
    o.rem = r[15:0];
    return o;
  endfunction

endpackage

// File: rtl/mte_div.sv
module mte_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mte_pkg::div_st_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mte_pkg::div_st_t out_data
);

  localparam int unsigned N = mte_pkg::NumStages;

  logic             v    [N];
  mte_pkg::div_st_t st   [N];
  logic             rdy  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [1:0] DBits = 2'(mte_pkg::UsecPerMin >> (24 - 2 * i));
    logic             src_v;
    mte_pkg::div_st_t src_d;
    logic             down_rdy;

    if (i == 0) begin : g_first
      assign src_v = in_valid;
      assign src_d = in_data;
    end else begin : g_mid
      assign src_v = v[i-1];
      assign src_d = st[i-1];
    end

    if (i == N - 1) begin : g_last
      assign down_rdy = !out_stall;
    end else begin : g_nlast
      assign down_rdy = rdy[i+1];
    end

    // stage advances when empty or when the next one takes its item
    assign rdy[i] = !v[i] || down_rdy;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) begin
        st[i] <= mte_pkg::div_step(src_d, DBits);
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v[N-1];
  assign out_data  = st[N-1];

endmodule

// File: rtl/mte_ser.sv
module mte_ser (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mte_pkg::div_st_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             last
);

  logic [7:0] bytes [10];
  logic [3:0] cnt;
  logic [7:0] nb    [10];
  logic [3:0] ncnt;
  logic       load;
  logic       xfer;

  // assemble the byte list of one event
  always_comb begin
    logic [7:0]  db [4];
    logic [7:0]  eb [6];
    logic [2:0]  ng;
    logic [2:0]  ne;
    logic [7:0]  vel;
    logic [23:0] q;
    ng = 3'd1;
    if (in_data.delta[27:7] != '0)  ng = 3'd2;
    if (in_data.delta[27:14] != '0) ng = 3'd3;
    if (in_data.delta[27:21] != '0) ng = 3'd4;
    for (int k = 0; k < 4; k++) begin
      db[k] = 8'h00;
    end
    unique case (ng)
      3'd1: begin
        db[0] = {1'b0, in_data.delta[6:0]};
      end
      3'd2: begin
        db[0] = {1'b1, in_data.delta[13:7]};
        db[1] = {1'b0, in_data.delta[6:0]};
      end
      3'd3: begin
        db[0] = {1'b1, in_data.delta[20:14]};
        db[1] = {1'b1, in_data.delta[13:7]};
        db[2] = {1'b0, in_data.delta[6:0]};
      end
      default: begin
        db[0] = {1'b1, in_data.delta[27:21]};
        db[1] = {1'b1, in_data.delta[20:14]};
        db[2] = {1'b1, in_data.delta[13:7]};
        db[3] = {1'b0, in_data.delta[6:0]};
      end
    endcase
    vel = (in_data.chan > 4'd6) ? 8'd0 : 8'h64 - {in_data.chan, 4'h0};
    if (in_data.bzero || in_data.quot[25:24] != 2'b00) begin
      q = mte_pkg::QuotMax;
    end else begin
      q = in_data.quot[23:0];
    end
    for (int k = 0; k < 6; k++) begin
      eb[k] = 8'h00;
    end
    unique case (in_data.kind)
      mte_pkg::KIND_NOTE_ON, mte_pkg::KIND_NOTE_OFF: begin
        eb[0] = ((in_data.kind == mte_pkg::KIND_NOTE_ON) ? 8'h90 : 8'h80)
                + {4'h0, in_data.chan};
        eb[1] = {1'b0, in_data.note};
        eb[2] = vel;
        ne    = 3'd3;
      end
      mte_pkg::KIND_TEMPO: begin
        eb[0] = 8'hFF;
        eb[1] = 8'h51;
        eb[2] = 8'h03;
        eb[3] = q[23:16];
        eb[4] = q[15:8];
        eb[5] = q[7:0];
        ne    = 3'd6;
      end
      default: begin
        ne = 3'd0;
      end
    endcase
    for (int k = 0; k < 10; k++) begin
      if (k < 32'(ng)) begin
        nb[k] = db[k[1:0]];
      end else if ((k - 32'(ng)) < 6) begin
        nb[k] = eb[3'(k - 32'(ng))];
      end else begin
        nb[k] = 8'h00;
      end
    end
    ncnt = {1'b0, ng} + {1'b0, ne};
  end

  assign xfer     = out_valid && !out_stall;
  assign in_stall = (cnt != 4'd0) && !(xfer && cnt == 4'd1);
  assign load     = in_valid && !in_stall;

  // remaining byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
    end else if (load) begin
      cnt <= ncnt;
    end else if (xfer) begin
      cnt <= cnt - 4'd1;
    end
  end

  // byte shift line, head is the outgoing byte
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= nb;
    end else if (xfer) begin
      for (int k = 0; k < 9; k++) begin
        bytes[k] <= bytes[k+1];
      end
      bytes[9] <= 8'h00;
    end
  end

  assign out_valid = (cnt != 4'd0);
  assign out_byte  = bytes[0];
  assign last      = (cnt == 4'd1);

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (xfer && !last) |=> out_valid) else $error("event cut short");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid) else $error("loaded event not shown");
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(out_byte) && $stable(last)))
    else $error("stalled byte changed");

endmodule

// File: rtl/midi_track_event_encoder.sv
// an event passes the 13 divider stages, then loads into the byte stage and shows
// its first byte on the output; an event is 1 to 10 bytes
// the serializer sends one byte per cycle unless out_stall is high, and loads the next
// event as the last byte leaves; the divider accepts every cycle unless stalled
// reset: synchronous, active high, empties all stages and the serializer
module midi_track_event_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [27:0] delta_ticks,
  input  logic [3:0]  channel,
  input  logic [6:0]  note_number,
  input  logic [15:0] tempo_bpm,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last
);

  mte_pkg::div_st_t in_st;
  mte_pkg::div_st_t dv_st;
  logic             dv_valid;
  logic             dv_stall;

  // pack the event for the divider
  always_comb begin
    in_st       = '0;
    in_st.kind  = mte_pkg::kind_t'(kind);
    in_st.delta = delta_ticks;
    in_st.chan  = channel;
    in_st.note  = note_number;
    in_st.bzero = (tempo_bpm == 16'd0);
    in_st.dvs   = tempo_bpm;
  end

  mte_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_st),
    .out_valid (dv_valid),
    .out_stall (dv_stall),
    .out_data  (dv_st)
  );

  mte_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_stall  (dv_stall),
    .in_data   (dv_st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule
